// ----- hw/rtl/qpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qpa_pkg
// Shared types, constants and helpers of the quadtree page allocator.
// ----------------------------------------------------------------------------
package qpa_pkg;

    localparam int LEVELS   = 6;
    localparam int TAG_BITS = 8;
    localparam int NODES    = ((1 << (2 * LEVELS)) - 1) / 3;
    localparam int ADDR_W   = $clog2(NODES);
    localparam int CNT_W    = $clog2(NODES + 1);
    localparam int LVL_W    = $clog2(LEVELS + 1);

    // fixed field widths
    localparam int EXP_W    = 4;
    localparam int SIZE_W   = 16;
    localparam int OWNER_W  = 8;
    localparam int STAT_W   = 3;
    localparam int INDEX_W  = 11;
    localparam int OFS_W    = 15;
    localparam int SIDE_W   = 16;
    localparam int CIDX_W   = 2;
    localparam int LOCAL_W  = (LEVELS > 1) ? (LEVELS - 1) : 1;

    localparam logic [CIDX_W-1:0] CFG_TOP_EXP = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_MIN_EXP = 2'd1;

    typedef enum logic [1:0] {
        NS_ABSENT = 2'd0,
        NS_FREE   = 2'd1,
        NS_USED   = 2'd2
    } t_node_stat;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_NO_SPACE = 3'd1,
        ST_TOO_SMALL = 3'd2,
        ST_TOO_BIG  = 3'd3,
        ST_NO_OWNER = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        MT_FREE,
        MT_USED,
        MT_NOT_FREE
    } t_match;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_SPLIT,
        S_MARK,
        S_FREE,
        S_MSCAN,
        S_MERGE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [0:0]         req_type;
        logic [SIZE_W-1:0]  page_size;
        logic [OWNER_W-1:0] owner_tag;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [INDEX_W-1:0] page_index;
        logic [OFS_W-1:0]   offset_x;
        logic [OFS_W-1:0]   offset_y;
        logic [SIDE_W-1:0]  atlas_side;
        logic [OWNER_W-1:0] owner_echo;
    } t_res;

    // command from front end to sequencer
    typedef struct packed {
        logic                rel;
        logic [LVL_W-1:0]    depth;
        logic [TAG_BITS-1:0] tag;
    } t_cmd;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] node;
    } t_rsp;

    // store write request
    typedef struct packed {
        logic                en;
        logic                own_en;
        logic [ADDR_W-1:0]   addr;
        t_node_stat          stat;
        logic [TAG_BITS-1:0] own;
    } t_wr;

    // index of the first node at depth d
    function automatic logic [CNT_W-1:0] depth_first(input logic [LVL_W-1:0] d);
        logic [CNT_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (i < int'(d)) begin
                sum = sum + CNT_W'(1 << (2 * i));
            end
        end
        return sum;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/qpa_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qpa_store
// Node status and owner memories, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module qpa_store
    import qpa_pkg::*;
(
    input  wire logic                i_clk,
    input  wire t_wr                 i_wr,
    input  wire logic [ADDR_W-1:0]   i_raddr,
    output t_node_stat               o_rd_stat,
    output logic [TAG_BITS-1:0]      o_rd_own
);

    t_node_stat          r_stat_mem [NODES];
    logic [TAG_BITS-1:0] r_own_mem  [NODES];

    // status memory
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_stat_mem[i_wr.addr] <= i_wr.stat;
        end
        o_rd_stat <= r_stat_mem[i_raddr];
    end

    // owner memory
    always_ff @(posedge i_clk) begin
        if (i_wr.own_en) begin
            r_own_mem[i_wr.addr] <= i_wr.own;
        end
        o_rd_own <= r_own_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- hw/rtl/qpa_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qpa_seq
// Sequencer: level scans, split and merge walks and the store clearing pass.
// ----------------------------------------------------------------------------
module qpa_seq
    import qpa_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_clear,
    input  wire logic                i_go,
    input  wire t_cmd                i_cmd,
    output logic                     o_busy,
    output logic                     o_done,
    output t_rsp                     o_rsp,
    output t_wr                      o_wr,
    output logic [ADDR_W-1:0]        o_raddr,
    input  wire t_node_stat          i_rd_stat,
    input  wire logic [TAG_BITS-1:0] i_rd_own
);

    t_state              r_state, n_state;
    t_match              r_match, n_match;
    t_status             r_status, n_status;
    logic                r_rel, n_rel;
    logic [LVL_W-1:0]    r_d, n_d;
    logic [LVL_W-1:0]    r_j, n_j;
    logic [TAG_BITS-1:0] r_tag, n_tag;
    logic [ADDR_W-1:0]   r_node, n_node;
    logic [ADDR_W-1:0]   r_res_node, n_res_node;
    logic [2:0]          r_k, n_k;
    logic [CNT_W-1:0]    r_addr, n_addr;
    logic [CNT_W-1:0]    r_end, n_end;
    logic                r_pv, n_pv;
    logic [ADDR_W-1:0]   r_paddr, n_paddr;

    logic                hit;
    logic                issue;
    logic                scan_end;
    logic [ADDR_W-1:0]   child;
    logic [ADDR_W-1:0]   parent;
    logic [ADDR_W-1:0]   base;

    // state and scan registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_pv    <= n_pv;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_match    <= n_match;
        r_status   <= n_status;
        r_rel      <= n_rel;
        r_d        <= n_d;
        r_j        <= n_j;
        r_tag      <= n_tag;
        r_node     <= n_node;
        r_res_node <= n_res_node;
        r_k        <= n_k;
        r_end      <= n_end;
        r_paddr    <= n_paddr;
    end

    // tree neighbors of the current node
    always_comb begin
        child  = ADDR_W'({r_node, 2'b00} + (ADDR_W + 2)'(1));
        parent = ADDR_W'((r_node - ADDR_W'(1)) >> 2);
        base   = ADDR_W'({parent, 2'b00} + (ADDR_W + 2)'(1));
    end

    // scan compare on the registered read data
    always_comb begin
        hit = 1'b0;
        if (r_pv) begin
            case (r_match)
                MT_FREE:     hit = (i_rd_stat == NS_FREE);
                MT_USED:     hit = (i_rd_stat == NS_USED) && (i_rd_own == r_tag);
                MT_NOT_FREE: hit = (i_rd_stat != NS_FREE);
                default:     hit = 1'b0;
            endcase
        end
        issue    = (r_addr != r_end) && !hit;
        scan_end = !r_pv && (r_addr == r_end);
    end

    assign o_raddr = r_addr[ADDR_W-1:0];
    assign o_busy  = (r_state != S_IDLE);
    assign o_done  = (r_state == S_DONE);
    assign o_rsp   = '{status: r_status, node: r_res_node};

    // next state and store requests
    always_comb begin
        n_state    = r_state;
        n_match    = r_match;
        n_status   = r_status;
        n_rel      = r_rel;
        n_d        = r_d;
        n_j        = r_j;
        n_tag      = r_tag;
        n_node     = r_node;
        n_res_node = r_res_node;
        n_k        = r_k;
        n_addr     = r_addr;
        n_end      = r_end;
        n_pv       = 1'b0;
        n_paddr    = r_paddr;
        o_wr       = '0;

        // shared scan pipeline
        if ((r_state == S_SCAN) || (r_state == S_MSCAN)) begin
            n_pv    = issue;
            n_paddr = r_addr[ADDR_W-1:0];
            if (issue) begin
                n_addr = r_addr + CNT_W'(1);
            end
        end

        case (r_state)
            S_CLEAR: begin
                o_wr.en   = 1'b1;
                o_wr.addr = r_addr[ADDR_W-1:0];
                o_wr.stat = (r_addr == '0) ? NS_FREE : NS_ABSENT;
                n_addr    = r_addr + CNT_W'(1);
                if (r_addr == CNT_W'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_go) begin
                    n_rel      = i_cmd.rel;
                    n_d        = i_cmd.depth;
                    n_j        = i_cmd.depth;
                    n_tag      = i_cmd.tag;
                    n_res_node = '0;
                    n_match    = i_cmd.rel ? MT_USED : MT_FREE;
                    n_addr     = depth_first(i_cmd.depth);
                    n_end      = depth_first(LVL_W'(i_cmd.depth + LVL_W'(1)));
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_pv       = 1'b0;
                    n_node     = r_paddr;
                    n_res_node = r_paddr;
                    n_k        = '0;
                    if (r_rel) begin
                        n_state = S_FREE;
                    end else if (r_j == r_d) begin
                        n_state = S_MARK;
                    end else begin
                        n_state = S_SPLIT;
                    end
                end else if (scan_end) begin
                    if (r_rel) begin
                        n_status = ST_NO_OWNER;
                        n_state  = S_DONE;
                    end else if (r_j == '0) begin
                        n_status = ST_NO_SPACE;
                        n_state  = S_DONE;
                    end else begin
                        // retry one level up
                        n_j    = r_j - LVL_W'(1);
                        n_addr = depth_first(r_j - LVL_W'(1));
                        n_end  = depth_first(r_j);
                    end
                end
            end
            S_SPLIT: begin
                o_wr.en = 1'b1;
                if (r_k == '0) begin
                    o_wr.addr = r_node;
                    o_wr.stat = NS_ABSENT;
                end else begin
                    o_wr.addr = child + ADDR_W'(r_k);
                    o_wr.stat = NS_FREE;
                end
                n_k = r_k + 3'd1;
                if (r_k == 3'd3) begin
                    n_k        = '0;
                    n_node     = child;
                    n_res_node = child;
                    n_j        = r_j + LVL_W'(1);
                    if ((r_j + LVL_W'(1)) == r_d) begin
                        n_state = S_MARK;
                    end
                end
            end
            S_MARK: begin
                o_wr.en     = 1'b1;
                o_wr.own_en = 1'b1;
                o_wr.addr   = r_node;
                o_wr.stat   = NS_USED;
                o_wr.own    = r_tag;
                n_status    = ST_OK;
                n_state     = S_DONE;
            end
            S_FREE: begin
                o_wr.en   = 1'b1;
                o_wr.addr = r_node;
                o_wr.stat = NS_FREE;
                n_status  = ST_OK;
                if (r_node == '0) begin
                    n_state = S_DONE;
                end else begin
                    // look for a sibling that is not free
                    n_match = MT_NOT_FREE;
                    n_addr  = CNT_W'(base);
                    n_end   = CNT_W'(base) + CNT_W'(4);
                    n_state = S_MSCAN;
                end
            end
            S_MSCAN: begin
                if (hit) begin
                    n_pv    = 1'b0;
                    n_state = S_DONE;
                end else if (scan_end) begin
                    n_k     = '0;
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                o_wr.en = 1'b1;
                if (r_k == 3'd4) begin
                    o_wr.addr = parent;
                    o_wr.stat = NS_FREE;
                    n_node    = parent;
                    n_k       = '0;
                    n_state   = S_FREE;
                end else begin
                    o_wr.addr = base + ADDR_W'(r_k);
                    o_wr.stat = NS_ABSENT;
                    n_k       = r_k + 3'd1;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // clear request restarts the clearing pass
        if (i_clear) begin
            n_state = S_CLEAR;
            n_addr  = '0;
            n_pv    = 1'b0;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/quadtree_page_allocator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadtree_page_allocator_top
// Quadtree buddy allocator for square pages of a square texture atlas.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge with start high and busy low. It acquires
// (req_type 0) or releases (req_type 1) a page; exactly one result follows,
// shown on o_res for one cycle with o_res_strobe high. The receiver cannot
// stall, so a result is never held.
// A request rejected on its size is shown in the cycle after it is taken.
// Otherwise the sequencer scans the status memory one node per cycle through
// its single read port: an acquire scans the wanted level and then shallower
// levels until a free node is found (up to all 1365 nodes), and each split
// marks the parent absent and three children free; a release scans one
// level (up to 1024 nodes), and each merge step marks four free siblings
// absent and their parent free. Busy stays high until the result has been
// shown, so one request is in flight at a time. Reset and every write of
// register 0 or 1 start a clearing pass that leaves one free root; busy is
// high during it. Register writes on i_cfg_* take effect at once.
// ----------------------------------------------------------------------------
module quadtree_page_allocator_top
    import qpa_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire t_req               i_req,
    output logic                    o_res_strobe,
    output t_res                    o_res,
    input  wire logic               i_cfg_we,
    input  wire logic [CIDX_W-1:0]  i_cfg_idx,
    input  wire logic [EXP_W-1:0]   i_cfg_data
);

    logic [EXP_W-1:0]    r_top_exp;
    logic [EXP_W-1:0]    r_min_exp;
    logic                r_busy;
    logic                r_out_valid;
    t_res                r_res;
    logic [EXP_W-1:0]    r_e;
    logic [LVL_W-1:0]    r_d;
    logic [OWNER_W-1:0]  r_owner;

    logic                accept;
    logic                cfg_hit;
    logic [EXP_W-1:0]    dec_e;
    logic [EXP_W-1:0]    dec_span;
    t_status             dec_status;
    t_cmd                cmd;
    logic                seq_busy;
    logic                seq_done;
    t_rsp                seq_rsp;
    t_wr                 wr;
    logic [ADDR_W-1:0]   raddr;
    t_node_stat          rd_stat;
    logic [TAG_BITS-1:0] rd_own;
    logic [ADDR_W-1:0]   local_idx;
    logic [LOCAL_W-1:0]  gx;
    logic [LOCAL_W-1:0]  gy;
    logic [OFS_W-1:0]    ofs_x;
    logic [OFS_W-1:0]    ofs_y;

    assign busy    = r_busy | seq_busy;
    assign accept  = start && !busy;
    assign cfg_hit = i_cfg_we && ((i_cfg_idx == CFG_TOP_EXP) || (i_cfg_idx == CFG_MIN_EXP));

    // page exponent and size checks
    always_comb begin
        dec_e = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (i_req.page_size[i]) begin
                dec_e = EXP_W'(i);
            end
        end
        dec_span = r_top_exp - dec_e;
        if (i_req.page_size == '0) begin
            dec_status = ST_TOO_SMALL;
        end else if (dec_e > r_top_exp) begin
            dec_status = ST_TOO_BIG;
        end else if ((dec_e < r_min_exp) || (int'(dec_span) >= LEVELS)) begin
            dec_status = ST_TOO_SMALL;
        end else begin
            dec_status = ST_OK;
        end
        cmd.rel   = i_req.req_type[0];
        cmd.depth = LVL_W'(dec_span);
        cmd.tag   = i_req.owner_tag[TAG_BITS-1:0];
    end

    // pixel offset from the node's place within its level
    always_comb begin
        local_idx = seq_rsp.node - ADDR_W'(depth_first(r_d));
        for (int i = 0; i < LOCAL_W; i++) begin
            gx[i] = (2 * i < ADDR_W) ? local_idx[2 * i] : 1'b0;
            gy[i] = (2 * i + 1 < ADDR_W) ? local_idx[2 * i + 1] : 1'b0;
        end
        ofs_x = OFS_W'(gx) << r_e;
        ofs_y = OFS_W'(gy) << r_e;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_exp <= EXP_W'(10);
            r_min_exp <= EXP_W'(5);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_TOP_EXP) begin
                r_top_exp <= i_cfg_data;
            end else if (i_cfg_idx == CFG_MIN_EXP) begin
                r_min_exp <= i_cfg_data;
            end
        end
    end

    // request tracking and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            if (r_out_valid) begin
                r_busy <= 1'b0;
            end
            if (accept) begin
                r_busy <= 1'b1;
                if (dec_status != ST_OK) begin
                    r_out_valid <= 1'b1;
                end
            end
            if (seq_done && r_busy) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_e     <= dec_e;
            r_d     <= cmd.depth;
            r_owner <= i_req.owner_tag;
            r_res   <= '{status: dec_status, page_index: '0, offset_x: '0,
                         offset_y: '0, atlas_side: SIDE_W'(1) << r_top_exp,
                         owner_echo: i_req.owner_tag};
        end else if (seq_done) begin
            r_res.status     <= seq_rsp.status;
            r_res.atlas_side <= SIDE_W'(1) << r_top_exp;
            r_res.owner_echo <= r_owner;
            if (seq_rsp.status == ST_OK) begin
                r_res.page_index <= INDEX_W'(seq_rsp.node);
                r_res.offset_x   <= ofs_x;
                r_res.offset_y   <= ofs_y;
            end else begin
                r_res.page_index <= '0;
                r_res.offset_x   <= '0;
                r_res.offset_y   <= '0;
            end
        end
    end

    assign o_res_strobe = r_out_valid;
    assign o_res        = r_res;

    // allocation sequencer
    qpa_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (cfg_hit),
        .i_go      (accept && (dec_status == ST_OK)),
        .i_cmd     (cmd),
        .o_busy    (seq_busy),
        .o_done    (seq_done),
        .o_rsp     (seq_rsp),
        .o_wr      (wr),
        .o_raddr   (raddr),
        .i_rd_stat (rd_stat),
        .i_rd_own  (rd_own)
    );

    // node store
    qpa_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_raddr   (raddr),
        .o_rd_stat (rd_stat),
        .o_rd_own  (rd_own)
    );

endmodule
`default_nettype wire
